>>> src/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned BlockSizeW   = 16;
  localparam int unsigned BpbW         = 9;
  localparam int unsigned BucketCountW = 3;

  localparam int unsigned BucketW = 2;
  localparam int unsigned BlockW  = 8;
  localparam int unsigned OffsetW = 24;
  localparam int unsigned UsedW   = 11;
  localparam int unsigned CountW  = 32;

  localparam int unsigned WordW    = 32;
  localparam int unsigned WordSelW = 5;
  localparam int unsigned PopW     = 6;

  localparam logic [BlockSizeW-1:0]   BlockSizeReset   = 16'd64;
  localparam logic [BpbW-1:0]         BpbReset         = 9'd256;
  localparam logic [BucketCountW-1:0] BucketCountReset = 3'd4;
  localparam logic [CountW-1:0]       SuccessWrap      = 32'hffff_ffff;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLOCK_SIZE        = 2'd0,
    REG_BLOCKS_PER_BUCKET = 2'd1,
    REG_BUCKET_COUNT      = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_RANGE   = 2'd2,
    STATUS_ALREADY = 2'd3
  } status_e;

  typedef struct packed {
    logic accept;
    logic select;
    logic read;
    logic modify;
    logic load_out;
    logic sweep;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic bpb_wr;
    logic sweep_done;
  } ctrl_sts_t;

endpackage

>>> src/bba_if.sv
// Request and response channel interfaces of the bitmap block allocator.
// Widths follow bba_pkg.
`timescale 1ns / 1ps

interface bba_req_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [bba_pkg::BucketW-1:0]    bucket_in;
  logic [bba_pkg::BlockW-1:0]     block_in;

  modport source (output valid, cmd, bucket_in, block_in, input ready);
  modport sink   (input valid, cmd, bucket_in, block_in, output ready);
endinterface

interface bba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [bba_pkg::BucketW-1:0]    bucket_out;
  logic [bba_pkg::BlockW-1:0]     block_out;
  logic [bba_pkg::OffsetW-1:0]    byte_offset;
  logic [bba_pkg::UsedW-1:0]      used_blocks;
  logic [bba_pkg::CountW-1:0]     success_count;
  logic [bba_pkg::CountW-1:0]     fail_count;

  modport source (output valid, status, bucket_out, block_out, byte_offset, used_blocks,
                  success_count, fail_count, input ready);
  modport sink   (input valid, status, bucket_out, block_out, byte_offset, used_blocks,
                  success_count, fail_count, output ready);
endinterface

>>> src/bba_ctrl.sv
// Sequencer of the bitmap block allocator: steps a request through
// select, read, modify and respond, and runs the free-count recount sweep. Uses bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bba_pkg::ctrl_sts_t  sts_i,
  output bba_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEL   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_SWEEP = 3'd5;

  logic [2:0] state_q, state_d;
  logic       ready;
  logic       accept;

  assign ready  = !sts_i.bpb_wr &&
                  ((state_q == S_IDLE) || ((state_q == S_DONE) && sts_i.slot_free));
  assign accept = in_valid_i && ready;

  assign in_ready_o      = ready;
  assign cmd_o.accept    = accept;
  assign cmd_o.select    = (state_q == S_SEL);
  assign cmd_o.read      = (state_q == S_RD);
  assign cmd_o.modify    = (state_q == S_MOD);
  assign cmd_o.load_out  = (state_q == S_DONE) && sts_i.slot_free;
  assign cmd_o.sweep     = (state_q == S_SWEEP);

  always_comb begin
    state_d = state_q;
    if (sts_i.bpb_wr) begin
      state_d = S_SWEEP;
    end else begin
      unique case (state_q)
        S_IDLE:  if (accept) state_d = S_SEL;
        S_SEL:   state_d = S_RD;
        S_RD:    state_d = S_MOD;
        S_MOD:   state_d = S_DONE;
        S_DONE: begin
          if (sts_i.slot_free) state_d = accept ? S_SEL : S_IDLE;
        end
        S_SWEEP: if (sts_i.sweep_done) state_d = S_IDLE;
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/bba_datapath.sv
// Datapath of the bitmap block allocator: config registers, bitmap word memory
// with per-word valid and full flags, free counts, counters and result register. Uses bba_pkg.
`timescale 1ns / 1ps

module bba_datapath #(
  parameter int unsigned BUCKETS           = 4,
  parameter int unsigned BLOCKS_PER_BUCKET = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bba_pkg::ctrl_cmd_t                 cmd_i,
  output bba_pkg::ctrl_sts_t                 sts_o,
  input  logic                               cfg_we_i,
  input  logic [bba_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [bba_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               req_cmd_i,
  input  logic [bba_pkg::BucketW-1:0]        req_bucket_i,
  input  logic [bba_pkg::BlockW-1:0]         req_block_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [1:0]                         out_status_o,
  output logic [bba_pkg::BucketW-1:0]        out_bucket_o,
  output logic [bba_pkg::BlockW-1:0]         out_block_o,
  output logic [bba_pkg::OffsetW-1:0]        out_offset_o,
  output logic [bba_pkg::UsedW-1:0]          out_used_o,
  output logic [bba_pkg::CountW-1:0]         out_success_o,
  output logic [bba_pkg::CountW-1:0]         out_fail_o
);

  localparam int unsigned NB    = (BUCKETS < 4) ? BUCKETS : 4;
  localparam int unsigned NBLK  = (BLOCKS_PER_BUCKET < 256) ? BLOCKS_PER_BUCKET : 256;
  localparam int unsigned WPB   = (NBLK + 31) / 32;
  localparam int unsigned WW    = (WPB > 1) ? $clog2(WPB) : 1;
  localparam int unsigned BW    = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned AW    = BW + WW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned WPS   = 2 ** WW;

  localparam logic [bba_pkg::BpbW-1:0]         NblkV = bba_pkg::BpbW'(NBLK);
  localparam logic [bba_pkg::BucketCountW-1:0] NbV   = bba_pkg::BucketCountW'(NB);

  // config
  logic [bba_pkg::BlockSizeW-1:0]   block_size_q;
  logic [bba_pkg::BpbW-1:0]         bpb_q;
  logic [bba_pkg::BucketCountW-1:0] bcnt_q;
  logic                             bpb_wr;
  logic [bba_pkg::BpbW-1:0]         n_new;
  logic [bba_pkg::BpbW-1:0]         n_eff;
  logic [bba_pkg::BucketCountW-1:0] nb_eff;
  logic [bba_pkg::BpbW:0]           n_round;
  logic [4:0]                       words_used;

  // request
  bba_pkg::cmd_e                    cmd_q;
  logic [bba_pkg::BucketW-1:0]      bkt_q;
  logic [bba_pkg::BlockW-1:0]       blk_q;
  logic                             range_ok;

  // selection
  logic [WW-1:0]                    wsel [NB];
  logic [NB-1:0]                    wfound;
  logic                             found;
  logic [BW-1:0]                    sel_b;
  logic [WW-1:0]                    sel_w;
  logic [AW-1:0]                    addr_q;
  logic                             hit_q;
  logic [bba_pkg::WordSelW-1:0]     bitpos_q;

  // bitmap memory
  logic [bba_pkg::WordW-1:0]        mem_q [DEPTH];
  logic [DEPTH-1:0]                 wvalid_q;
  logic [DEPTH-1:0]                 full_q;
  logic [bba_pkg::WordW-1:0]        rdata_q;
  logic                             rvld_q;
  logic [AW-1:0]                    raddr;
  logic                             re;
  logic [bba_pkg::WordW-1:0]        word;

  // modify
  logic [bba_pkg::WordSelW-1:0]     zpos;
  logic                             is_set;
  logic                             alloc_set;
  logic                             free_clr;
  logic                             mem_we;
  logic [bba_pkg::WordW-1:0]        wdata;
  logic [BW-1:0]                    mod_b;

  // free counts and sweep
  logic [bba_pkg::BpbW-1:0]         free_q [NB];
  logic [AW:0]                      sw_cnt_q;
  logic                             sw_vld_q;
  logic [AW-1:0]                    sw_addr_q;
  logic [bba_pkg::BpbW:0]           sw_base;
  logic [bba_pkg::BpbW:0]           sw_rem;
  logic [bba_pkg::WordW-1:0]        sw_mask;
  logic [bba_pkg::PopW-1:0]         pc;

  // counters and result
  logic [bba_pkg::CountW-1:0]       succ_q;
  logic [bba_pkg::CountW-1:0]       succ_inc;
  logic [bba_pkg::CountW-1:0]       fail_q;
  bba_pkg::status_e                 res_st_q;
  logic [bba_pkg::BucketW-1:0]      res_b_q;
  logic [bba_pkg::BlockW-1:0]       res_idx_q;
  logic [bba_pkg::UsedW-1:0]        used;
  logic                             out_valid_q;
  logic [1:0]                       out_status_q;
  logic [bba_pkg::BucketW-1:0]      out_bucket_q;
  logic [bba_pkg::BlockW-1:0]       out_block_q;
  logic [bba_pkg::OffsetW-1:0]      out_offset_q;
  logic [bba_pkg::UsedW-1:0]        out_used_q;
  logic [bba_pkg::CountW-1:0]       out_success_q;
  logic [bba_pkg::CountW-1:0]       out_fail_q;

  // ---------------- config ----------------
  assign bpb_wr = cfg_we_i && (cfg_idx_i == bba_pkg::REG_BLOCKS_PER_BUCKET);
  assign n_new  = (cfg_data_i[bba_pkg::BpbW-1:0] > NblkV) ? NblkV
                                                          : cfg_data_i[bba_pkg::BpbW-1:0];
  assign n_eff  = (bpb_q > NblkV) ? NblkV : bpb_q;
  assign nb_eff = (bcnt_q > NbV) ? NbV : bcnt_q;
  assign n_round    = {1'b0, n_eff} + 10'd31;
  assign words_used = n_round[bba_pkg::BpbW:5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= bba_pkg::BlockSizeReset;
      bpb_q        <= bba_pkg::BpbReset;
      bcnt_q       <= bba_pkg::BucketCountReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bba_pkg::REG_BLOCK_SIZE) begin
        block_size_q <= cfg_data_i[bba_pkg::BlockSizeW-1:0];
      end
      if (cfg_idx_i == bba_pkg::REG_BLOCKS_PER_BUCKET) begin
        bpb_q <= cfg_data_i[bba_pkg::BpbW-1:0];
      end
      if (cfg_idx_i == bba_pkg::REG_BUCKET_COUNT) begin
        bcnt_q <= cfg_data_i[bba_pkg::BucketCountW-1:0];
      end
    end
  end

  // ---------------- request capture ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= bba_pkg::cmd_e'(req_cmd_i);
      bkt_q <= req_bucket_i;
      blk_q <= req_block_i;
    end
  end

  assign range_ok = ({1'b0, bkt_q} < nb_eff) && ({1'b0, blk_q} < n_eff);

  // ---------------- first-fit selection ----------------
  // lowest non-full word in range per bucket; the free count guarantees its
  // lowest clear bit sits below the bucket size
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      wsel[b]   = '0;
      wfound[b] = 1'b0;
      for (int w = WPS - 1; w >= 0; w--) begin
        if ((5'(w) < words_used) && !full_q[{BW'(b), WW'(w)}]) begin
          wsel[b]   = WW'(w);
          wfound[b] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    found = 1'b0;
    sel_b = '0;
    sel_w = '0;
    for (int b = NB - 1; b >= 0; b--) begin
      if ((3'(b) < nb_eff) && (free_q[b] != '0) && wfound[b]) begin
        found = 1'b1;
        sel_b = BW'(b);
        sel_w = wsel[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.select) begin
      bitpos_q <= blk_q[bba_pkg::WordSelW-1:0];
      if (cmd_q == bba_pkg::CMD_ALLOC) begin
        addr_q <= {sel_b, sel_w};
        hit_q  <= found;
      end else begin
        addr_q <= {bkt_q[BW-1:0], blk_q[bba_pkg::WordSelW +: WW]};
        hit_q  <= range_ok;
      end
    end
  end

  // ---------------- bitmap memory ----------------
  assign raddr = cmd_i.sweep ? sw_cnt_q[AW-1:0] : addr_q;
  assign re    = cmd_i.read || (cmd_i.sweep && !sw_cnt_q[AW]);
  assign word  = rvld_q ? rdata_q : '0;

  always_comb begin
    zpos = '0;
    for (int i = bba_pkg::WordW - 1; i >= 0; i--) begin
      if (!word[i]) zpos = bba_pkg::WordSelW'(i);
    end
  end

  assign is_set    = word[bitpos_q];
  assign alloc_set = (cmd_q == bba_pkg::CMD_ALLOC) && hit_q;
  assign free_clr  = (cmd_q == bba_pkg::CMD_FREE) && hit_q && is_set;
  assign mem_we    = cmd_i.modify && (alloc_set || free_clr);
  assign wdata     = alloc_set ? (word | (32'h1 << zpos)) : (word & ~(32'h1 << bitpos_q));
  assign mod_b     = addr_q[AW-1:WW];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= '0;
      full_q   <= '0;
      rvld_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        wvalid_q[addr_q] <= 1'b1;
        full_q[addr_q]   <= &wdata;
      end
      if (re) begin
        rvld_q <= wvalid_q[raddr];
      end
    end
  end

  // ---------------- recount sweep ----------------
  assign sw_base = {{(bba_pkg::BpbW + 1 - WW - bba_pkg::WordSelW){1'b0}},
                    sw_addr_q[WW-1:0], {bba_pkg::WordSelW{1'b0}}};
  assign sw_rem  = {1'b0, n_eff} - sw_base;

  always_comb begin
    if ({1'b0, n_eff} <= sw_base) begin
      sw_mask = '0;
    end else if (sw_rem >= 10'd32) begin
      sw_mask = '1;
    end else begin
      sw_mask = ~(32'hffff_ffff << sw_rem[bba_pkg::WordSelW-1:0]);
    end
  end

  always_comb begin
    pc = '0;
    for (int i = 0; i < bba_pkg::WordW; i++) begin
      pc = pc + bba_pkg::PopW'(word[i] & sw_mask[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_cnt_q  <= '0;
      sw_vld_q  <= 1'b0;
      sw_addr_q <= '0;
    end else if (bpb_wr) begin
      sw_cnt_q <= '0;
      sw_vld_q <= 1'b0;
    end else if (cmd_i.sweep && !sw_cnt_q[AW]) begin
      sw_cnt_q  <= sw_cnt_q + 1'b1;
      sw_vld_q  <= 1'b1;
      sw_addr_q <= sw_cnt_q[AW-1:0];
    end else begin
      sw_vld_q <= 1'b0;
    end
  end

  // ---------------- free counts ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NB; b++) free_q[b] <= NblkV;
    end else begin
      for (int b = 0; b < NB; b++) begin
        if (bpb_wr) begin
          free_q[b] <= n_new;
        end else if (cmd_i.sweep && sw_vld_q && (sw_addr_q[AW-1:WW] == BW'(b))) begin
          free_q[b] <= free_q[b] - bba_pkg::BpbW'(pc);
        end else if (cmd_i.modify && (mod_b == BW'(b))) begin
          if (alloc_set) begin
            free_q[b] <= free_q[b] - 1'b1;
          end else if (free_clr) begin
            free_q[b] <= free_q[b] + 1'b1;
          end
        end
      end
    end
  end

  // ---------------- counters ----------------
  assign succ_inc = succ_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      succ_q <= '0;
      fail_q <= '0;
    end else if (cmd_i.modify && (cmd_q == bba_pkg::CMD_ALLOC)) begin
      if (hit_q) begin
        succ_q <= (succ_inc == bba_pkg::SuccessWrap) ? '0 : succ_inc;
      end else begin
        fail_q <= fail_q + 1'b1;
      end
    end
  end

  // ---------------- result ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.modify) begin
      res_b_q   <= '0;
      res_idx_q <= '0;
      if (cmd_q == bba_pkg::CMD_ALLOC) begin
        if (hit_q) begin
          res_st_q  <= bba_pkg::STATUS_OK;
          res_b_q   <= bba_pkg::BucketW'(mod_b);
          res_idx_q <= bba_pkg::BlockW'({addr_q[WW-1:0], zpos});
        end else begin
          res_st_q <= bba_pkg::STATUS_NO_FREE;
        end
      end else if (!hit_q) begin
        res_st_q <= bba_pkg::STATUS_RANGE;
      end else if (!is_set) begin
        res_st_q <= bba_pkg::STATUS_ALREADY;
      end else begin
        res_st_q <= bba_pkg::STATUS_OK;
      end
    end
  end

  always_comb begin
    used = '0;
    for (int b = 0; b < NB; b++) begin
      if (3'(b) < nb_eff) used = used + bba_pkg::UsedW'(n_eff - free_q[b]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q  <= res_st_q;
      out_bucket_q  <= res_b_q;
      out_block_q   <= res_idx_q;
      out_offset_q  <= bba_pkg::OffsetW'(res_idx_q) * bba_pkg::OffsetW'(block_size_q);
      out_used_q    <= used;
      out_success_q <= succ_q;
      out_fail_q    <= fail_q;
    end
  end

  assign sts_o.slot_free  = !out_valid_q || out_ready_i;
  assign sts_o.bpb_wr     = bpb_wr;
  assign sts_o.sweep_done = sw_cnt_q[AW];

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_bucket_o  = out_bucket_q;
  assign out_block_o   = out_block_q;
  assign out_offset_o  = out_offset_q;
  assign out_used_o    = out_used_q;
  assign out_success_o = out_success_q;
  assign out_fail_o    = out_fail_q;

endmodule

>>> src/bitmap_block_allocator.sv
// Bitmap first-fit block allocator, top level. Uses bba_pkg, bba_if, bba_ctrl, bba_datapath.
// An accepted request passes through select, memory read, modify and respond; the
// response register loads in the respond step once the output slot is free. One request
// is in flight at a time, with the next request taken in the respond step. Writing
// blocks_per_bucket starts a recount sweep of every bitmap word with no request accepted.
// Reset (async, active low): all blocks free, counters zero, registers 64 / 256 / 4.
`timescale 1ns / 1ps

module bitmap_block_allocator #(
  parameter int unsigned BUCKETS           = 4,
  parameter int unsigned BLOCKS_PER_BUCKET = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bba_req_if.sink                       req,
  bba_rsp_if.source                     rsp,
  input  logic                          cfg_we_i,
  input  logic [bba_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bba_pkg::CfgDataW-1:0]  cfg_data_i
);

  bba_pkg::ctrl_cmd_t ctrl_cmd;
  bba_pkg::ctrl_sts_t ctrl_sts;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  bba_datapath #(
    .BUCKETS           (BUCKETS),
    .BLOCKS_PER_BUCKET (BLOCKS_PER_BUCKET)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .sts_o         (ctrl_sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_cmd_i     (req.cmd),
    .req_bucket_i  (req.bucket_in),
    .req_block_i   (req.block_in),
    .out_ready_i   (rsp.ready),
    .out_valid_o   (rsp.valid),
    .out_status_o  (rsp.status),
    .out_bucket_o  (rsp.bucket_out),
    .out_block_o   (rsp.block_out),
    .out_offset_o  (rsp.byte_offset),
    .out_used_o    (rsp.used_blocks),
    .out_success_o (rsp.success_count),
    .out_fail_o    (rsp.fail_count)
  );

endmodule

>>> src/bba_checker.sv
// Port-level checks for the bitmap block allocator, bound to the top level.
// Uses bba_pkg.
`timescale 1ns / 1ps

module bba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [1:0]                    rsp_status_i,
  input logic [bba_pkg::BucketW-1:0]   rsp_bucket_i,
  input logic [bba_pkg::BlockW-1:0]    rsp_block_i,
  input logic [bba_pkg::OffsetW-1:0]   rsp_offset_i,
  input logic [bba_pkg::CountW-1:0]    rsp_success_i,
  input logic [bba_pkg::CountW-1:0]    rsp_fail_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_block_i) && $stable(rsp_offset_i) &&
      $stable(rsp_success_i) && $stable(rsp_fail_i))
    else $error("response payload changed while stalled");

  a_no_block_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != bba_pkg::STATUS_OK) |->
      (rsp_bucket_i == '0) && (rsp_block_i == '0) && (rsp_offset_i == '0))
    else $error("failed request reports a block");

  a_success_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_success_i != bba_pkg::SuccessWrap))
    else $error("success count reached its wrap value");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .rsp_status_i  (rsp.status),
  .rsp_bucket_i  (rsp.bucket_out),
  .rsp_block_i   (rsp.block_out),
  .rsp_offset_i  (rsp.byte_offset),
  .rsp_success_i (rsp.success_count),
  .rsp_fail_i    (rsp.fail_count)
);
